// ----- src/sde_pkg.sv -----
// shared types and constants for the sierpinski distance estimate unit
package sde_pkg;

   localparam int NUM_VTX    = 4;
   localparam int FIELD_W    = 21;
   localparam int REQ_DATA_W = 64;
   localparam int DIST_W     = 22;
   localparam int CORNER_W   = 2;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_W      = 63;

   // register index, taken from paddr[4:3]
   typedef enum logic [1:0] {
      REG_VERTEX_A = 2'd0,
      REG_VERTEX_B = 2'd1,
      REG_VERTEX_C = 2'd2,
      REG_VERTEX_D = 2'd3
   } reg_idx_type;

   // valid flag and nearest corner that travel along both cell rows
   typedef struct packed {
      logic                valid;
      logic [CORNER_W-1:0] corner;
   } sde_tag_type;

endpackage

// ----- src/sde_iter_cell.sv -----
// one fractal iteration: squares, distance sums, nearest pick and vertex pull-in (no pull-in when LAST)
module sde_iter_cell #(
   parameter int CW   = 21,
   parameter bit LAST = 1'b0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  sde_pkg::sde_tag_type        tag_i,
   input  logic [2:0][CW-1:0]          pnt_i,
   input  logic [3:0][2:0][CW-1:0]     vtx_i,
   output sde_pkg::sde_tag_type        tag_o,
   output logic [2:0][CW-1:0]          pnt_o,
   output logic [3:0][2:0][CW-1:0]     vtx_o,
   output logic [2*CW+1:0]             dsq_o
);
   import sde_pkg::*;

   localparam int SQ_W = 2*CW + 2;

   // stage a: per-axis squares
   logic                       vld_a_ff, vld_a_in;
   logic [2:0][CW-1:0]         pnt_a_ff;
   logic [3:0][2:0][CW-1:0]    vtx_a_ff;
   logic [3:0][2:0][SQ_W-1:0]  sq_a_ff, sq_a_in;
   // stage b: distance sums
   logic                       vld_b_ff;
   logic [2:0][CW-1:0]         pnt_b_ff;
   logic [3:0][2:0][CW-1:0]    vtx_b_ff;
   logic [3:0][SQ_W-1:0]       sum_b_ff, sum_b_in;
   // stage c: pick and move
   sde_tag_type                tag_c_ff, tag_c_in;
   logic [2:0][CW-1:0]         pnt_c_ff;
   logic [3:0][2:0][CW-1:0]    vtx_c_ff, vtx_c_in;
   logic [SQ_W-1:0]            dsq_c_ff, dsq_c_in;

   assign vld_a_in = tag_i.valid;

   always_comb begin
      logic signed [CW:0]       d;
      logic signed [SQ_W-1:0]   prod;
      for (int j = 0; j < NUM_VTX; j++) begin
         for (int c = 0; c < 3; c++) begin
            d    = $signed({vtx_i[j][c][CW-1], vtx_i[j][c]}) -
                   $signed({pnt_i[c][CW-1], pnt_i[c]});
            prod = d * d;
            sq_a_in[j][c] = $unsigned(prod);
         end
      end
   end

   always_comb begin
      for (int j = 0; j < NUM_VTX; j++) begin
         sum_b_in[j] = sq_a_ff[j][0] + sq_a_ff[j][1] + sq_a_ff[j][2];
      end
   end

   always_comb begin
      logic [CORNER_W-1:0]  best;
      logic [SQ_W-1:0]      best_sq;
      logic signed [CW:0]   delta;
      logic signed [CW:0]   half;
      best    = '0;
      best_sq = sum_b_ff[0];
      // strict less keeps the lowest index on ties
      for (int j = 1; j < NUM_VTX; j++) begin
         if (sum_b_ff[j] < best_sq) begin
            best_sq = sum_b_ff[j];
            best    = CORNER_W'(j);
         end
      end
      vtx_c_in = vtx_b_ff;
      if (!LAST) begin
         for (int j = 0; j < NUM_VTX; j++) begin
            for (int c = 0; c < 3; c++) begin
               delta = $signed({vtx_b_ff[best][c][CW-1], vtx_b_ff[best][c]}) -
                       $signed({vtx_b_ff[j][c][CW-1], vtx_b_ff[j][c]});
               // halve toward zero
               half  = (delta + $signed({{CW{1'b0}}, delta[CW]})) >>> 1;
               if (CORNER_W'(j) != best) begin
                  vtx_c_in[j][c] = vtx_b_ff[j][c] + half[CW-1:0];
               end
            end
         end
      end
      tag_c_in.valid  = vld_b_ff;
      tag_c_in.corner = best;
      dsq_c_in        = best_sq;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff       <= 1'b0;
         vld_b_ff       <= 1'b0;
         tag_c_ff.valid <= 1'b0;
      end else if (en) begin
         vld_a_ff       <= vld_a_in;
         vld_b_ff       <= vld_a_ff;
         tag_c_ff       <= tag_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pnt_a_ff        <= pnt_i;
         vtx_a_ff        <= vtx_i;
         sq_a_ff         <= sq_a_in;
         pnt_b_ff        <= pnt_a_ff;
         vtx_b_ff        <= vtx_a_ff;
         sum_b_ff        <= sum_b_in;
         pnt_c_ff        <= pnt_b_ff;
         vtx_c_ff        <= vtx_c_in;
         dsq_c_ff        <= dsq_c_in;
      end
   end

   assign tag_o = tag_c_ff;
   assign pnt_o = pnt_c_ff;
   assign vtx_o = vtx_c_ff;
   assign dsq_o = dsq_c_ff;

endmodule

// ----- src/sde_sqrt_cell.sv -----
// one root bit of the floor square root chain
module sde_sqrt_cell #(
   parameter int CW  = 21,
   parameter int BIT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  sde_pkg::sde_tag_type  tag_i,
   input  logic [2*CW+1:0]       rem_i,
   input  logic [CW:0]           root_i,
   output sde_pkg::sde_tag_type  tag_o,
   output logic [2*CW+1:0]       rem_o,
   output logic [CW:0]           root_o
);
   import sde_pkg::*;

   localparam int SQ_W  = 2*CW + 2;
   localparam int RES_W = CW + 1;

   sde_tag_type          tag_ff;
   logic [SQ_W-1:0]      rem_ff, rem_in;
   logic [RES_W-1:0]     root_ff, root_in;

   always_comb begin
      logic [SQ_W:0] trial;
      // (root + 2^bit)^2 - root^2
      trial = ({{(SQ_W+1-RES_W){1'b0}}, root_i} << (BIT+1)) +
              ((SQ_W+1)'(1) << (2*BIT));
      if ({1'b0, rem_i} >= trial) begin
         rem_in  = rem_i - trial[SQ_W-1:0];
         root_in = root_i | (RES_W'(1) << BIT);
      end else begin
         rem_in  = rem_i;
         root_in = root_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff.valid <= 1'b0;
      end else if (en) begin
         tag_ff       <= tag_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff        <= rem_in;
         root_ff       <= root_in;
      end
   end

   assign tag_o  = tag_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// ----- src/sierpinski_distance_estimate_unit.sv -----
// top level: config registers, row of iteration cells, square root chain, output register
// pipeline: three register stages per iteration cell, one per root bit, one output register
// throughput: one beat per cycle; the whole row freezes while a response waits
// reset clears all valid flags and the vertex registers; payload registers are not reset
module sierpinski_distance_estimate_unit #(
   parameter int ITERATIONS = 32,
   parameter int COORD_BITS = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_x [20:0], point_y [41:21], point_z [62:42]
   input  logic [sde_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // distance [21:0], nearest_corner [23:22]
   output logic [sde_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [sde_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sde_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [sde_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import sde_pkg::*;

   localparam int CW    = COORD_BITS;
   localparam int SQ_W  = 2*CW + 2;
   localparam int RES_W = CW + 1;

   logic [NUM_VTX-1:0][REG_W-1:0] vtx_reg_ff;
   reg_idx_type                   csr_idx;
   logic                          en;

   // config port
   assign csr_idx    = reg_idx_type'(csr_paddr[4:3]);
   assign csr_pready = 1'b1;
   assign csr_prdata = {1'b0, vtx_reg_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vtx_reg_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         vtx_reg_ff[csr_idx] <= csr_pwdata[REG_W-1:0];
      end
   end

   // global stall: whole pipe advances only when the output slot can take a beat
   logic                 rsp_vld_ff;
   logic [DIST_W-1:0]    rsp_dist_ff;
   logic [CORNER_W-1:0]  rsp_corner_ff;

   assign en         = !rsp_vld_ff || rsp_tready;
   assign req_tready = en;

   // iteration cell row
   sde_tag_type               it_tag [ITERATIONS+1];
   logic [2:0][CW-1:0]        it_pnt [ITERATIONS+1];
   logic [3:0][2:0][CW-1:0]   it_vtx [ITERATIONS+1];
   logic [SQ_W-1:0]           it_dsq [ITERATIONS+1];

   assign it_tag[0]        = {req_tvalid, CORNER_W'(0)};
   assign it_dsq[0]        = '0;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         it_pnt[0][c] = req_tdata[c*FIELD_W +: CW];
         for (int j = 0; j < NUM_VTX; j++) begin
            it_vtx[0][j][c] = vtx_reg_ff[j][c*CW +: CW];
         end
      end
   end

   for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
      sde_iter_cell #(
         .CW   (CW),
         .LAST (k == ITERATIONS-1)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .en    (en),
         .tag_i (it_tag[k]),
         .pnt_i (it_pnt[k]),
         .vtx_i (it_vtx[k]),
         .tag_o (it_tag[k+1]),
         .pnt_o (it_pnt[k+1]),
         .vtx_o (it_vtx[k+1]),
         .dsq_o (it_dsq[k+1])
      );
   end

   // square root chain, msb first
   sde_tag_type        sq_tag  [RES_W+1];
   logic [SQ_W-1:0]    sq_rem  [RES_W+1];
   logic [RES_W-1:0]   sq_root [RES_W+1];

   assign sq_tag[0]  = it_tag[ITERATIONS];
   assign sq_rem[0]  = it_dsq[ITERATIONS];
   assign sq_root[0] = '0;

   for (genvar k = 0; k < RES_W; k++) begin : g_sqrt
      sde_sqrt_cell #(
         .CW  (CW),
         .BIT (RES_W-1-k)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .tag_i  (sq_tag[k]),
         .rem_i  (sq_rem[k]),
         .root_i (sq_root[k]),
         .tag_o  (sq_tag[k+1]),
         .rem_o  (sq_rem[k+1]),
         .root_o (sq_root[k+1])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= sq_tag[RES_W].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_dist_ff   <= DIST_W'(sq_root[RES_W]);
         rsp_corner_ff <= sq_tag[RES_W].corner;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {rsp_corner_ff, rsp_dist_ff};

   // checks
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("request taken while response stalled");
   a_prdata_top: assert property (@(posedge clock) disable iff (reset)
      csr_prdata[CSR_DATA_W-1] == 1'b0)
      else $error("unused register bit set");

endmodule

// ----- tb/sv/sierpinski_distance_estimate_unit_tb.sv -----
// self-checking testbench for the sierpinski distance estimate unit
module sierpinski_distance_estimate_unit_tb;
   import sde_pkg::*;

   localparam int ROUNDS      = 32;
   localparam int LATENCY     = 3 * ROUNDS + FIELD_W + 2;
   localparam int STALL_LIMIT = 5000;

   typedef struct {
      logic [DIST_W-1:0]   distance;
      logic [CORNER_W-1:0] corner;
   } estimate_type;

   typedef struct {
      logic [REQ_DATA_W-1:0] data;
      bit                    typed;
      logic [DIST_W-1:0]     distance;
      logic [CORNER_W-1:0]   corner;
   } point_row_type;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel = 0;
   logic                  csr_penable = 0;
   logic                  csr_pwrite = 0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   estimate_type    pending_estimates[$];
   logic [REG_W-1:0] vertex_shadow[NUM_VTX];
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_off_left = 0;
   int              fail_count = 0;
   int              quiet_cycles = 0;

   sierpinski_distance_estimate_unit #(.ITERATIONS(ROUNDS), .COORD_BITS(FIELD_W)) uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic longint coord(logic [REG_W-1:0] w, int k);
      logic [FIELD_W-1:0] f;
      f = w[k*FIELD_W +: FIELD_W];
      return longint'($signed(f));
   endfunction

   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned root;
      longint unsigned bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > n) bitpos >>= 2;
      while (bitpos != 0) begin
         if (n >= root + bitpos) begin
            n -= root + bitpos;
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   function automatic estimate_type estimate_distance(logic [REQ_DATA_W-1:0] pt);
      longint p[3];
      longint v[NUM_VTX][3];
      longint d;
      longint unsigned sq, best_sq;
      int best;
      estimate_type e;
      best_sq = 0;
      best = 0;
      for (int k = 0; k < 3; k++) p[k] = coord(pt[REG_W-1:0], k);
      for (int j = 0; j < NUM_VTX; j++)
         for (int k = 0; k < 3; k++) v[j][k] = coord(vertex_shadow[j], k);
      for (int it = 0; it < ROUNDS; it++) begin
         best = 0;
         for (int j = 0; j < NUM_VTX; j++) begin
            sq = 0;
            for (int k = 0; k < 3; k++) begin
               d = v[j][k] - p[k];
               sq += longint'(d * d);
            end
            if (j == 0 || sq < best_sq) begin
               best_sq = sq;
               best = j;
            end
         end
         if (it == ROUNDS - 1) break;
         // signed division truncates toward zero
         for (int j = 0; j < NUM_VTX; j++)
            if (j != best)
               for (int k = 0; k < 3; k++) v[j][k] = v[j][k] + (v[best][k] - v[j][k]) / 2;
      end
      e.distance = DIST_W'(floor_root(best_sq));
      e.corner = CORNER_W'(best);
      return e;
   endfunction

   function automatic logic [REG_W-1:0] pack_point(longint x, longint y, longint z);
      logic [FIELD_W-1:0] fx, fy, fz;
      fx = FIELD_W'(x);
      fy = FIELD_W'(y);
      fz = FIELD_W'(z);
      return {fz, fy, fx};
   endfunction

   task automatic write_vertex(reg_idx_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      vertex_shadow[idx] = val[REG_W-1:0];
   endtask

   task automatic send_point(logic [REQ_DATA_W-1:0] data, bit typed = 0,
                             logic [DIST_W-1:0] distance = '0,
                             logic [CORNER_W-1:0] corner = '0);
      estimate_type e;
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (typed) begin
         e.distance = distance;
         e.corner = corner;
      end else begin
         e = estimate_distance(data);
      end
      pending_estimates = {pending_estimates, e};
   endtask

   task automatic wait_all_results();
      req_tvalid <= 0;
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   function automatic logic [REQ_DATA_W-1:0] random_point(bit near);
      logic [REQ_DATA_W-1:0] r;
      if (near)
         r = {1'($urandom), pack_point($signed($urandom_range(0, 32767)) - 16384,
                                       $signed($urandom_range(0, 32767)) - 16384,
                                       $signed($urandom_range(0, 32767)) - 16384)};
      else
         r = {$urandom, $urandom};
      return r;
   endfunction

   // receiver stall pattern and long hold-off
   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      estimate_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_estimates.size() == 0) begin
            $error("unexpected response beat %h", rsp_tdata);
            fail_count++;
         end else begin
            e = pending_estimates.pop_front();
            if (rsp_tdata[DIST_W-1:0] !== e.distance) begin
               $error("distance: expected %0d, got %0d", e.distance, rsp_tdata[DIST_W-1:0]);
               fail_count++;
            end
            if (rsp_tdata[DIST_W +: CORNER_W] !== e.corner) begin
               $error("nearest_corner: expected %0d, got %0d", e.corner,
                      rsp_tdata[DIST_W +: CORNER_W]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   point_row_type directed_rows[] = '{
      '{64'd0, 1, 22'd0, 2'd0},
      '{{1'b0, pack_point(1, 0, 0)}, 1, 22'd1, 2'd0},
      '{{1'b0, pack_point(-1, 0, 0)}, 1, 22'd1, 2'd0},
      '{{1'b0, pack_point(0, 4096, 0)}, 1, 22'd4096, 2'd0},
      '{{1'b0, pack_point(0, 0, -4096)}, 1, 22'd4096, 2'd0},
      '{{1'b1, pack_point(0, 0, 0)}, 1, 22'd0, 2'd0},
      '{{1'b0, pack_point(-1048576, 0, 0)}, 1, 22'd1048576, 2'd0},
      '{{1'b0, pack_point(1048575, 1048575, 1048575)}, 0, 22'd0, 2'd0},
      '{{1'b0, pack_point(-1048576, -1048576, -1048576)}, 0, 22'd0, 2'd0},
      '{{1'b1, pack_point(1048575, -1048576, 12345)}, 0, 22'd0, 2'd0}
   };

   // vertex sets: extremes, a tie (a equals b), coincident, then random ones
   logic [REG_W-1:0] vertex_sets[6][NUM_VTX];

   initial begin
      reg_idx_type idx;
      foreach (vertex_shadow[j]) vertex_shadow[j] = '0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_idle_pct = 30;
      recv_idle_pct = 62;
      foreach (directed_rows[i])
         send_point(directed_rows[i].data, directed_rows[i].typed,
                    directed_rows[i].distance, directed_rows[i].corner);
      wait_all_results();

      vertex_sets[0] = '{pack_point(1048575, 1048575, 1048575),
                         pack_point(-1048576, -1048576, -1048576),
                         pack_point(1048575, -1048576, 0), '1};
      vertex_sets[1] = '{pack_point(4096, 0, 0), pack_point(4096, 0, 0),
                         pack_point(-4096, 0, 0), pack_point(0, 4096, 4096)};
      vertex_sets[2] = '{pack_point(777, -5, 9), pack_point(777, -5, 9),
                         pack_point(777, -5, 9), pack_point(777, -5, 9)};
      for (int s = 3; s < 6; s++)
         foreach (vertex_sets[s][j])
            vertex_sets[s][j] = (s == 3) ? pack_point($signed($urandom_range(0, 65535)) - 32768,
                                                      $signed($urandom_range(0, 65535)) - 32768,
                                                      $signed($urandom_range(0, 65535)) - 32768)
                                         : REG_W'({$urandom, $urandom});

      for (int s = 0; s < 6; s++) begin
         if (s == 2) begin
            send_idle_pct = 62;
            recv_idle_pct = 30;
         end else if (s == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (int j = 0; j < NUM_VTX; j++) begin
            idx = reg_idx_type'(j);
            // top bit is unused and must be ignored
            write_vertex(idx, {1'($urandom), vertex_sets[s][j]});
         end
         if (s == 1) begin
            // equidistant from a and b, the tie goes to a
            send_point({1'b0, pack_point(4096, 100, -100)});
            send_point({1'b0, pack_point(0, 0, 0)});
         end
         for (int n = 0; n < 205; n++) begin
            if (s == 1 && n == 20) hold_off_left = 400;
            if (s == 3 && n == 100) wait_all_results();
            send_point(random_point(1'($urandom_range(1))));
         end
         wait_all_results();
      end

      repeat (LATENCY + 30) @(posedge clock);
      if (fail_count == 0 && pending_estimates.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/sde_pkg.sv
src/sde_iter_cell.sv
src/sde_sqrt_cell.sv
src/sierpinski_distance_estimate_unit.sv
tb/sv/sierpinski_distance_estimate_unit_tb.sv
